// ===== rtl/core/absg_pkg.sv =====
// shared types and constants of the authenticated bit share gate engine
package absg_pkg;

    localparam int ADDR_W   = 10;
    localparam int CMD_W    = 4;
    localparam int FIELD_W  = 64;
    localparam int SIZE_W   = 11;
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic              FP_RESET   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ = 4'd0,
        CMD_PRIV = 4'd1,
        CMD_PUB  = 4'd2,
        CMD_ZERO = 4'd3,
        CMD_ONE  = 4'd4,
        CMD_XOR  = 4'd5,
        CMD_INV  = 4'd6,
        CMD_AND  = 4'd7,
        CMD_OPEN = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNSET = 2'd2
    } t_status;

    typedef struct packed {
        logic [FIELD_W-1:0] delta;
        logic               first_party;
        logic [SIZE_W-1:0]  store_size;
    } t_cfg;

endpackage

// ===== rtl/core/absg_cmd_if.sv =====
// command channel carrying one gate command per beat
interface absg_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [absg_pkg::CMD_W-1:0]  cmd;
    logic [absg_pkg::ADDR_W-1:0] dst;
    logic [absg_pkg::ADDR_W-1:0] src_a;
    logic [absg_pkg::ADDR_W-1:0] src_b;
    logic [absg_pkg::ADDR_W-1:0] src_c;
    logic                        bit_in;
    logic                        second_bit;
    logic [absg_pkg::FIELD_W-1:0] mac_in;
    logic [absg_pkg::FIELD_W-1:0] key_in;
    logic [absg_pkg::FIELD_W-1:0] peer_mac;

    modport source (
        output valid, cmd, dst, src_a, src_b, src_c, bit_in, second_bit,
               mac_in, key_in, peer_mac,
        input  ready
    );
    modport sink (
        input  valid, cmd, dst, src_a, src_b, src_c, bit_in, second_bit,
               mac_in, key_in, peer_mac,
        output ready
    );
endinterface

// ===== rtl/core/absg_res_if.sv =====
// result channel carrying one share result per beat
interface absg_res_if;
    logic                         valid;
    logic                         ready;
    logic                         share_bit;
    logic [absg_pkg::FIELD_W-1:0] share_mac;
    logic [absg_pkg::FIELD_W-1:0] share_key;
    logic                         opened_bit;
    logic                         mac_ok;
    logic [1:0]                   status;

    modport source (
        output valid, share_bit, share_mac, share_key, opened_bit, mac_ok, status,
        input  ready
    );
    modport sink (
        input  valid, share_bit, share_mac, share_key, opened_bit, mac_ok, status,
        output ready
    );
endinterface

// ===== rtl/core/absg_cfg.sv =====
// apb configuration registers: delta, party role and store size
module absg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [absg_pkg::CFG_AW-1:0]   paddr,
    input  logic [absg_pkg::CFG_DW-1:0]   pwdata,
    output logic [absg_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output absg_pkg::t_cfg                o_cfg
);
    import absg_pkg::*;

    typedef enum logic [1:0] {
        REG_DELTA = 2'd0,
        REG_PARTY = 2'd1,
        REG_SIZE  = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    t_cfg r_cfg;
    t_reg reg_sel;
    logic wr_hit;

    assign reg_sel = t_reg'(paddr[4:3]);
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta       <= '0;
            r_cfg.first_party <= FP_RESET;
            r_cfg.store_size  <= SIZE_RESET;
        end else if (wr_hit) begin
            unique case (reg_sel)
                REG_DELTA: r_cfg.delta       <= pwdata;
                REG_PARTY: r_cfg.first_party <= pwdata[0];
                REG_SIZE:  r_cfg.store_size  <= pwdata[SIZE_W-1:0];
                REG_NONE:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DELTA: prdata = r_cfg.delta;
            REG_PARTY: prdata = CFG_DW'(r_cfg.first_party);
            REG_SIZE:  prdata = CFG_DW'(r_cfg.store_size);
            REG_NONE:  prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/absg_store.sv =====
// share store: entry memory, valid-mark memory and the post-reset clearing sweep
module absg_store #(
    parameter int DEPTH = 1024,
    parameter int DW    = 129
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DW-1:0]              o_rd_data,
    output logic                       o_rd_valid,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DW-1:0]              i_wr_data,
    output logic                       o_clr_busy
);
    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem_data [DEPTH];
    logic          mem_vld  [DEPTH];

    logic [AW-1:0] r_clr_idx;
    logic          r_clr_busy;
    logic [DW-1:0] r_rd_data;
    logic          r_rd_valid;

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;
    assign o_clr_busy = r_clr_busy;

    // sweep one valid mark per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_vld[r_clr_idx] <= 1'b0;
        end else if (i_wr_en) begin
            mem_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_data[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem_data[i_rd_addr];
            r_rd_valid <= mem_vld[i_rd_addr];
        end
    end

endmodule

// ===== rtl/core/absg_acc.sv =====
// shared xor accumulator folding gated operand shares
module absg_acc #(
    parameter int DW = 129
) (
    input  logic          i_clk,
    input  logic          i_clr,
    input  logic          i_en,
    input  logic          i_gate,
    input  logic [DW-1:0] i_data,
    output logic [DW-1:0] o_acc
);
    logic [DW-1:0] r_acc;

    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (i_en && i_gate) begin
            r_acc <= r_acc ^ i_data;
        end
    end

endmodule

// ===== rtl/core/authenticated_bit_share_gate_engine.sv =====
// top level of the authenticated bit share gate engine
//
// usage
//   i_cmd carries one gate command per beat (read, private load, public load,
//   zero, one, xor, invert, and-finish, open); o_res returns exactly one
//   result beat for each command. the apb port writes delta, the party role
//   and the store size; the user must do so only while the block is idle,
//   which the block itself does not enforce. pready is always high.
// operand walk
//   a command walks its n operands through S_RD and S_CHK, then passes
//   S_FIN into the output register; n is 0 for loads, zero and one, 1 for
//   read, invert and open, 2 for xor and 3 for and-finish. each operand is
//   one read of the single store read port followed by one valid check and
//   xor into the shared accumulator. an error stops the operand walk early.
//   one command is in flight at a time; i_cmd.ready is high only when idle.
// reset
//   control clears at once, then a clearing sweep resets every valid
//   mark; i_cmd.ready stays low during the sweep while apb writes are
//   taken as usual.
// stall
//   the result sits in an output register; a new command is accepted while it
//   waits, but the next result is held back until the old one is taken.
module authenticated_bit_share_gate_engine #(
    parameter int STORE_DEPTH = 1024,
    parameter int MAC_WIDTH   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    absg_cmd_if.sink                      i_cmd,
    absg_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [absg_pkg::CFG_AW-1:0]   paddr,
    input  logic [absg_pkg::CFG_DW-1:0]   pwdata,
    output logic [absg_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import absg_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int MW = MAC_WIDTH;
    localparam int DW = 2 * MW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FIN
    } t_state;

    // address is usable when below both store_size and the physical depth
    function automatic logic in_range(input logic [ADDR_W-1:0] a,
                                      input logic [SIZE_W-1:0] sz);
        logic below_size;
        logic below_depth;
        below_size  = ({1'b0, a} < sz);
        below_depth = (32'(a) < 32'(STORE_DEPTH));
        return below_size && below_depth;
    endfunction

    t_cfg cfg;

    // sequencer and captured command
    t_state              r_state;
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_dst;
    logic [ADDR_W-1:0]   r_sa;
    logic [ADDR_W-1:0]   r_sb;
    logic [ADDR_W-1:0]   r_sc;
    logic                r_bit;
    logic                r_bit2;
    logic [MW-1:0]       r_mac_in;
    logic [MW-1:0]       r_key_in;
    logic [MW-1:0]       r_peer;
    logic [1:0]          r_op;
    logic [1:0]          r_last;
    t_status             r_status;

    // output register
    logic                r_out_vld;
    logic                r_out_bit;
    logic [MW-1:0]       r_out_mac;
    logic [MW-1:0]       r_out_key;
    logic                r_out_opened;
    logic                r_out_ok;
    t_status             r_out_status;

    logic                accept;
    logic                clr_busy;
    logic                space;
    t_cmd                in_cmd;
    logic [1:0]          in_nops;
    logic                in_dst_need;
    t_status             in_dst_st;

    logic [ADDR_W-1:0]   op_addr;
    logic                op_ok;
    logic                rd_en;
    logic [DW-1:0]       rd_data;
    logic                rd_vbit;
    logic                acc_en;
    logic                acc_gate;
    logic [DW-1:0]       acc;

    logic                acc_bit;
    logic [MW-1:0]       acc_mac;
    logic [MW-1:0]       acc_key;
    logic [MW-1:0]       delta;

    logic                fin_wr;
    logic                fin_bit;
    logic [MW-1:0]       fin_mac;
    logic [MW-1:0]       fin_key;
    logic                fin_opened;
    logic                fin_ok;
    logic                fin_go;
    logic                wr_en;

    absg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    absg_store #(
        .DEPTH (STORE_DEPTH),
        .DW    (DW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (AW'(op_addr)),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_vbit),
        .i_wr_en    (wr_en),
        .i_wr_addr  (AW'(r_dst)),
        .i_wr_data  ({fin_bit, fin_mac, fin_key}),
        .o_clr_busy (clr_busy)
    );

    absg_acc #(
        .DW (DW)
    ) u_acc (
        .i_clk  (i_clk),
        .i_clr  (accept),
        .i_en   (acc_en),
        .i_gate (acc_gate),
        .i_data (rd_data),
        .o_acc  (acc)
    );

    // handshake
    assign i_cmd.ready = (r_state == S_IDLE) && !clr_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign space       = !r_out_vld || o_res.ready;

    // operand count and destination check of the incoming command
    assign in_cmd = t_cmd'(i_cmd.cmd);

    always_comb begin
        in_nops     = 2'd0;
        in_dst_need = 1'b0;
        unique case (in_cmd)
            CMD_READ, CMD_OPEN: in_nops = 2'd1;
            CMD_PRIV, CMD_PUB, CMD_ZERO, CMD_ONE: in_dst_need = 1'b1;
            CMD_XOR: begin
                in_nops     = 2'd2;
                in_dst_need = 1'b1;
            end
            CMD_INV: begin
                in_nops     = 2'd1;
                in_dst_need = 1'b1;
            end
            CMD_AND: begin
                in_nops     = 2'd3;
                in_dst_need = 1'b1;
            end
            default: ;
        endcase
    end

    assign in_dst_st = (in_dst_need && !in_range(i_cmd.dst, cfg.store_size)) ?
                       ST_RANGE : ST_OK;

    // operand walk: src_a, src_b, src_c
    always_comb begin
        unique case (r_op)
            2'd0:    op_addr = r_sa;
            2'd1:    op_addr = r_sb;
            default: op_addr = r_sc;
        endcase
    end

    assign op_ok  = in_range(op_addr, cfg.store_size);
    assign rd_en  = (r_state == S_RD) && op_ok;
    assign acc_en = (r_state == S_CHK) && rd_vbit;

    // and-finish folds y only when d is set and a only when e is set
    always_comb begin
        acc_gate = 1'b1;
        if (r_cmd == CMD_AND) begin
            unique case (r_op)
                2'd0:    acc_gate = r_bit;
                2'd1:    acc_gate = r_bit2;
                default: acc_gate = 1'b1;
            endcase
        end
    end

    assign acc_bit = acc[DW-1];
    assign acc_mac = acc[2*MW-1:MW];
    assign acc_key = acc[MW-1:0];
    assign delta   = cfg.delta[MW-1:0];

    // final share, open check and write decision
    always_comb begin
        logic v;
        v          = 1'b0;
        fin_wr     = 1'b0;
        fin_bit    = 1'b0;
        fin_mac    = '0;
        fin_key    = '0;
        fin_opened = 1'b0;
        fin_ok     = 1'b0;
        if (r_status == ST_OK) begin
            unique case (r_cmd)
                CMD_READ: begin
                    fin_bit = acc_bit;
                    fin_mac = acc_mac;
                    fin_key = acc_key;
                end
                CMD_PRIV: begin
                    fin_wr  = 1'b1;
                    fin_bit = r_bit;
                    fin_mac = r_mac_in;
                    fin_key = r_key_in;
                end
                CMD_PUB, CMD_ZERO, CMD_ONE: begin
                    fin_wr = 1'b1;
                    v      = (r_cmd == CMD_PUB) ? r_bit : (r_cmd == CMD_ONE);
                    // public constants: first party holds them in the key
                    if (cfg.first_party) begin
                        fin_key = v ? delta : '0;
                    end else begin
                        fin_bit = v;
                    end
                end
                CMD_XOR, CMD_AND: begin
                    fin_wr  = 1'b1;
                    fin_bit = acc_bit;
                    fin_mac = acc_mac;
                    fin_key = acc_key;
                end
                CMD_INV: begin
                    fin_wr  = 1'b1;
                    fin_bit = acc_bit ^ !cfg.first_party;
                    fin_mac = acc_mac;
                    fin_key = cfg.first_party ? (acc_key ^ delta) : acc_key;
                end
                CMD_OPEN: begin
                    fin_bit    = acc_bit;
                    fin_mac    = acc_mac;
                    fin_key    = acc_key;
                    fin_opened = acc_bit ^ r_bit;
                    fin_ok     = (r_peer == (acc_key ^ (r_bit ? delta : '0)));
                end
                default: ;  // unknown command: nothing happens, zero result
            endcase
        end
    end

    // result leaves the sequencer into the output register
    assign fin_go = (r_state == S_FIN) && space;
    assign wr_en  = fin_go && fin_wr;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && !fin_go) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= in_cmd;
                        r_dst    <= i_cmd.dst;
                        r_sa     <= i_cmd.src_a;
                        r_sb     <= i_cmd.src_b;
                        r_sc     <= i_cmd.src_c;
                        r_bit    <= i_cmd.bit_in;
                        r_bit2   <= i_cmd.second_bit;
                        r_mac_in <= i_cmd.mac_in[MW-1:0];
                        r_key_in <= i_cmd.key_in[MW-1:0];
                        r_peer   <= i_cmd.peer_mac[MW-1:0];
                        r_op     <= 2'd0;
                        r_last   <= in_nops - 2'd1;
                        r_status <= in_dst_st;
                        if (in_dst_st != ST_OK || in_nops == 2'd0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (!op_ok) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!rd_vbit) begin
                        r_status <= ST_UNSET;
                        r_state  <= S_FIN;
                    end else if (r_op == r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_op    <= r_op + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (space) begin
                        r_out_vld    <= 1'b1;
                        r_out_bit    <= fin_bit;
                        r_out_mac    <= fin_mac;
                        r_out_key    <= fin_key;
                        r_out_opened <= fin_opened;
                        r_out_ok     <= fin_ok;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.share_bit  = r_out_bit;
    assign o_res.share_mac  = FIELD_W'(r_out_mac);
    assign o_res.share_key  = FIELD_W'(r_out_key);
    assign o_res.opened_bit = r_out_opened;
    assign o_res.mac_ok     = r_out_ok;
    assign o_res.status     = r_out_status;

endmodule

// ===== rtl/core/absg_chk.sv =====
// port-level assertions for the gate engine, bound to the top level
module absg_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_res_share_bit,
    input  logic [absg_pkg::FIELD_W-1:0]  i_res_share_mac,
    input  logic [absg_pkg::FIELD_W-1:0]  i_res_share_key,
    input  logic                          i_res_opened,
    input  logic                          i_res_mac_ok,
    input  logic [1:0]                    i_res_status
);
    import absg_pkg::*;

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_status == ST_OK || i_res_status == ST_RANGE ||
                         i_res_status == ST_UNSET))
        else $error("undefined status code on result beat");

    // an error beat carries an all-zero share and no open result
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status != ST_OK) |->
            (!i_res_share_bit && i_res_share_mac == '0 && i_res_share_key == '0 &&
             !i_res_opened && !i_res_mac_ok))
        else $error("error beat carries nonzero fields");

    // one command in flight: ready drops right after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command accepted while previous one still in flight");

    // a stalled result beat stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result beat dropped under stall");

endmodule

bind authenticated_bit_share_gate_engine absg_chk u_absg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_share_bit (o_res.share_bit),
    .i_res_share_mac (o_res.share_mac),
    .i_res_share_key (o_res.share_key),
    .i_res_opened    (o_res.opened_bit),
    .i_res_mac_ok    (o_res.mac_ok),
    .i_res_status    (o_res.status)
);
